FILE: rtl/core/cbpe_pkg.sv
// ----------------------------------------------------------------------------
// cbpe_pkg
// shared widths, constants and types of the cubic bezier point evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package cbpe_pkg;

   // coordinate and curve parameter formats
   localparam int COORD_WIDTH = 16;
   localparam int T_FRAC_BITS = 15;
   localparam int T_WIDTH     = T_FRAC_BITS + 1;

   // control points and axes
   localparam int NUM_POINTS      = 4;
   localparam int NUM_AXES        = 3;
   localparam int CFG_WIDTH       = NUM_AXES * COORD_WIDTH;
   localparam int CFG_INDEX_WIDTH = $clog2(NUM_POINTS);
   localparam int CP_START        = 0;
   localparam int CP_END          = NUM_POINTS - 1;
   localparam int AXIS_X          = 0;
   localparam int AXIS_Y          = 1;
   localparam int AXIS_Z          = 2;

   // one quotient bit per divider stage
   localparam int DIV_STAGES = T_WIDTH;
   localparam int REM_WIDTH  = COORD_WIDTH + 1;

   // bernstein weights and the dot product
   localparam int BERN_MUL     = 3;
   localparam int WPROD_WIDTH  = 2 * T_WIDTH;
   localparam int WEIGHT_WIDTH = T_WIDTH + 1;
   localparam int PROD_WIDTH   = COORD_WIDTH + WEIGHT_WIDTH + 1;
   localparam int PAIR_WIDTH   = PROD_WIDTH + 1;
   localparam int ACC_WIDTH    = PAIR_WIDTH + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [COORD_WIDTH:0]   diff_type;
   typedef logic [COORD_WIDTH-1:0]        mag_type;
   typedef logic [T_WIDTH-1:0]            tparam_type;
   typedef logic [WEIGHT_WIDTH-1:0]       weight_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [PAIR_WIDTH-1:0]  pair_type;
   typedef logic signed [ACC_WIDTH-1:0]   acc_type;

   localparam tparam_type T_ONE = tparam_type'(1) << T_FRAC_BITS;
   localparam logic [WPROD_WIDTH-1:0] WPROD_HALF = WPROD_WIDTH'(1) << (T_FRAC_BITS - 1);
   localparam acc_type ACC_HALF      = acc_type'(1) <<< (T_FRAC_BITS - 1);
   localparam acc_type ACC_COORD_MAX = (acc_type'(1) <<< (COORD_WIDTH - 1)) - acc_type'(1);
   localparam acc_type ACC_COORD_MIN = -ACC_COORD_MAX - acc_type'(1);
   localparam coord_type COORD_MAX   = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN   = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   // side information that rides along the divider
   typedef struct packed {
      logic force_zero;
      logic force_one;
      logic clamped;
      logic degenerate;
   } div_side_type;

   // per-item status carried down the weight and product stages
   typedef struct packed {
      tparam_type t;
      logic       clamped;
      logic       degenerate;
   } meta_type;

endpackage

`default_nettype wire

FILE: rtl/core/cbpe_if.sv
// ----------------------------------------------------------------------------
// cbpe channel interfaces
// query word and result word channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface cbpe_req_if;
   logic                 valid;
   logic                 ready;
   cbpe_pkg::coord_type  query_x;

   modport source (output valid, output query_x, input ready);
   modport sink   (input valid, input query_x, output ready);
endinterface

interface cbpe_rsp_if;
   logic                 valid;
   logic                 ready;
   cbpe_pkg::coord_type  pos_x;
   cbpe_pkg::coord_type  pos_y;
   cbpe_pkg::coord_type  pos_z;
   cbpe_pkg::tparam_type param_t;
   logic                 clamped;
   logic                 degenerate;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output param_t, output clamped, output degenerate, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   input param_t, input clamped, input degenerate, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cubic_bezier_point_eval.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval
// a query word passes stages f1-f3, the divider, ts, w1-w3, pr, s1, s2 and the rsp register
// throughput: one query word per cycle; every stage holds while rsp is stalled
// the depth is set by the t divider, one quotient bit per stage (16 stages)
// reset clears all valid bits and the four control points to zero
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_point_eval (
   input  wire                                      clock,
   input  wire                                      reset,
   cbpe_req_if.sink                                 req_ch,
   cbpe_rsp_if.source                               rsp_ch,
   input  wire                                      csr_we,
   input  wire [cbpe_pkg::CFG_INDEX_WIDTH-1:0]      csr_index,
   input  wire [cbpe_pkg::CFG_WIDTH-1:0]            csr_wdata
);

   // round a Q30 weight product back to Q15
   function automatic cbpe_pkg::tparam_type rnd_weight(
      input logic [cbpe_pkg::WPROD_WIDTH-1:0] p
   );
      logic [cbpe_pkg::WPROD_WIDTH-1:0] s;
      s = p + cbpe_pkg::WPROD_HALF;
      return s[cbpe_pkg::T_FRAC_BITS +: cbpe_pkg::T_WIDTH];
   endfunction

   // round to nearest with ties up, then clip to the coordinate range
   function automatic cbpe_pkg::coord_type round_sat(input cbpe_pkg::acc_type acc);
      cbpe_pkg::acc_type biased;
      cbpe_pkg::acc_type shifted;
      biased  = acc + cbpe_pkg::ACC_HALF;
      shifted = biased >>> cbpe_pkg::T_FRAC_BITS;
      if (shifted > cbpe_pkg::ACC_COORD_MAX) begin
         return cbpe_pkg::COORD_MAX;
      end else if (shifted < cbpe_pkg::ACC_COORD_MIN) begin
         return cbpe_pkg::COORD_MIN;
      end
      return shifted[cbpe_pkg::COORD_WIDTH-1:0];
   endfunction

   // control point registers, x/y/z packed low to high
   logic [cbpe_pkg::CFG_WIDTH-1:0] cp_ff [cbpe_pkg::NUM_POINTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbpe_pkg::NUM_POINTS; i++) begin
            cp_ff[i] <= '0;
         end
      end else if (csr_we) begin
         cp_ff[csr_index] <= csr_wdata;
      end
   end

   // global stall: the whole pipe moves when the rsp register is free
   logic advance;
   logic rsp_valid_ff;
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // start and end x of the curve
   cbpe_pkg::coord_type x_start;
   cbpe_pkg::coord_type x_end;
   assign x_start = cbpe_pkg::coord_type'(cp_ff[cbpe_pkg::CP_START][cbpe_pkg::COORD_WIDTH-1:0]);
   assign x_end   = cbpe_pkg::coord_type'(cp_ff[cbpe_pkg::CP_END][cbpe_pkg::COORD_WIDTH-1:0]);

   // ---------------- stage f1: offset and span ----------------
   logic               f1_valid_ff;
   cbpe_pkg::diff_type f1_num_ff, f1_num_in;
   cbpe_pkg::diff_type f1_den_ff, f1_den_in;

   always_comb begin
      f1_num_in = cbpe_pkg::diff_type'(req_ch.query_x) - cbpe_pkg::diff_type'(x_start);
      f1_den_in = cbpe_pkg::diff_type'(x_end) - cbpe_pkg::diff_type'(x_start);
   end

   // ---------------- stage f2: magnitudes and sign checks ----------------
   logic               f2_valid_ff;
   cbpe_pkg::mag_type  f2_anum_ff, f2_anum_in;
   cbpe_pkg::mag_type  f2_aden_ff, f2_aden_in;
   logic               f2_degen_ff, f2_degen_in;
   logic               f2_neg_ff, f2_neg_in;
   cbpe_pkg::diff_type abs_num, abs_den;

   always_comb begin
      abs_num     = f1_num_ff[cbpe_pkg::COORD_WIDTH] ? -f1_num_ff : f1_num_ff;
      abs_den     = f1_den_ff[cbpe_pkg::COORD_WIDTH] ? -f1_den_ff : f1_den_ff;
      f2_anum_in  = abs_num[cbpe_pkg::COORD_WIDTH-1:0];
      f2_aden_in  = abs_den[cbpe_pkg::COORD_WIDTH-1:0];
      f2_degen_in = (f1_den_ff == '0);
      // t below zero: offset and span point opposite ways
      f2_neg_in   = (f1_num_ff != '0) &&
                    (f1_num_ff[cbpe_pkg::COORD_WIDTH] != f1_den_ff[cbpe_pkg::COORD_WIDTH]);
   end

   // ---------------- stage f3: clamp decision ----------------
   logic                   f3_valid_ff;
   cbpe_pkg::mag_type      f3_num_ff, f3_num_in;
   cbpe_pkg::mag_type      f3_den_ff;
   cbpe_pkg::div_side_type f3_side_ff, f3_side_in;
   logic                   over_one;

   always_comb begin
      over_one              = !f2_degen_ff && !f2_neg_ff && (f2_anum_ff > f2_aden_ff);
      f3_side_in.degenerate = f2_degen_ff;
      f3_side_in.clamped    = !f2_degen_ff && (f2_neg_ff || over_one);
      f3_side_in.force_zero = f2_degen_ff || f2_neg_ff;
      f3_side_in.force_one  = over_one;
      // forced cases divide zero so the divider never sees num > den
      f3_num_in = (f2_degen_ff || f2_neg_ff || over_one) ? '0 : f2_anum_ff;
   end

   // ---------------- divider: t = floor(num * 2^15 / den) ----------------
   logic                   dv_valid;
   cbpe_pkg::tparam_type   dv_quot;
   cbpe_pkg::div_side_type dv_side;

   cbpe_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (f3_valid_ff),
      .in_num   (f3_num_ff),
      .in_den   (f3_den_ff),
      .in_side  (f3_side_ff),
      .out_valid(dv_valid),
      .out_quot (dv_quot),
      .out_side (dv_side)
   );

   // ---------------- stage ts: select t, form u = 1 - t ----------------
   logic                 ts_valid_ff;
   cbpe_pkg::tparam_type ts_u_ff, ts_u_in;
   cbpe_pkg::meta_type   ts_meta_ff, ts_meta_in;

   always_comb begin
      if (dv_side.force_one) begin
         ts_meta_in.t = cbpe_pkg::T_ONE;
      end else if (dv_side.force_zero) begin
         ts_meta_in.t = '0;
      end else begin
         ts_meta_in.t = dv_quot;
      end
      ts_meta_in.clamped    = dv_side.clamped;
      ts_meta_in.degenerate = dv_side.degenerate;
      ts_u_in               = cbpe_pkg::T_ONE - ts_meta_in.t;
   end

   // ---------------- stage w1: squares ----------------
   logic                 w1_valid_ff;
   cbpe_pkg::tparam_type w1_uu_ff, w1_uu_in;
   cbpe_pkg::tparam_type w1_tt_ff, w1_tt_in;
   cbpe_pkg::tparam_type w1_u_ff;
   cbpe_pkg::meta_type   w1_meta_ff;
   logic [cbpe_pkg::WPROD_WIDTH-1:0] sq_u, sq_t;

   always_comb begin
      sq_u     = cbpe_pkg::WPROD_WIDTH'(ts_u_ff) * cbpe_pkg::WPROD_WIDTH'(ts_u_ff);
      sq_t     = cbpe_pkg::WPROD_WIDTH'(ts_meta_ff.t) * cbpe_pkg::WPROD_WIDTH'(ts_meta_ff.t);
      w1_uu_in = rnd_weight(sq_u);
      w1_tt_in = rnd_weight(sq_t);
   end

   // ---------------- stage w2: cubic terms ----------------
   logic                 w2_valid_ff;
   cbpe_pkg::tparam_type w2_raw_ff [cbpe_pkg::NUM_POINTS];
   cbpe_pkg::tparam_type w2_raw_in [cbpe_pkg::NUM_POINTS];
   cbpe_pkg::meta_type   w2_meta_ff;

   always_comb begin
      w2_raw_in[0] = rnd_weight(cbpe_pkg::WPROD_WIDTH'(w1_uu_ff) *
                                cbpe_pkg::WPROD_WIDTH'(w1_u_ff));
      w2_raw_in[1] = rnd_weight(cbpe_pkg::WPROD_WIDTH'(w1_uu_ff) *
                                cbpe_pkg::WPROD_WIDTH'(w1_meta_ff.t));
      w2_raw_in[2] = rnd_weight(cbpe_pkg::WPROD_WIDTH'(w1_tt_ff) *
                                cbpe_pkg::WPROD_WIDTH'(w1_u_ff));
      w2_raw_in[3] = rnd_weight(cbpe_pkg::WPROD_WIDTH'(w1_tt_ff) *
                                cbpe_pkg::WPROD_WIDTH'(w1_meta_ff.t));
   end

   // ---------------- stage w3: binomial factor on the middle weights ----------------
   logic                 w3_valid_ff;
   cbpe_pkg::weight_type w3_weight_ff [cbpe_pkg::NUM_POINTS];
   cbpe_pkg::weight_type w3_weight_in [cbpe_pkg::NUM_POINTS];
   cbpe_pkg::meta_type   w3_meta_ff;

   always_comb begin
      for (int i = 0; i < cbpe_pkg::NUM_POINTS; i++) begin
         if (i == 0 || i == cbpe_pkg::NUM_POINTS - 1) begin
            w3_weight_in[i] = cbpe_pkg::weight_type'(w2_raw_ff[i]);
         end else begin
            // times three as x + 2x
            w3_weight_in[i] = cbpe_pkg::weight_type'(w2_raw_ff[i]) + {w2_raw_ff[i], 1'b0};
         end
      end
   end

   // ---------------- stage pr: point times weight ----------------
   logic               pr_valid_ff;
   cbpe_pkg::prod_type pr_prod_ff [cbpe_pkg::NUM_AXES][cbpe_pkg::NUM_POINTS];
   cbpe_pkg::prod_type pr_prod_in [cbpe_pkg::NUM_AXES][cbpe_pkg::NUM_POINTS];
   cbpe_pkg::meta_type pr_meta_ff;

   always_comb begin
      for (int a = 0; a < cbpe_pkg::NUM_AXES; a++) begin
         for (int i = 0; i < cbpe_pkg::NUM_POINTS; i++) begin
            pr_prod_in[a][i] =
               cbpe_pkg::prod_type'($signed(cp_ff[i][a*cbpe_pkg::COORD_WIDTH +:
                                                     cbpe_pkg::COORD_WIDTH])) *
               cbpe_pkg::prod_type'($signed({1'b0, w3_weight_ff[i]}));
         end
      end
   end

   // ---------------- stage s1: pair sums ----------------
   logic               s1_valid_ff;
   cbpe_pkg::pair_type s1_lo_ff [cbpe_pkg::NUM_AXES];
   cbpe_pkg::pair_type s1_hi_ff [cbpe_pkg::NUM_AXES];
   cbpe_pkg::pair_type s1_lo_in [cbpe_pkg::NUM_AXES];
   cbpe_pkg::pair_type s1_hi_in [cbpe_pkg::NUM_AXES];
   cbpe_pkg::meta_type s1_meta_ff;

   always_comb begin
      for (int a = 0; a < cbpe_pkg::NUM_AXES; a++) begin
         s1_lo_in[a] = cbpe_pkg::pair_type'(pr_prod_ff[a][0]) +
                       cbpe_pkg::pair_type'(pr_prod_ff[a][1]);
         s1_hi_in[a] = cbpe_pkg::pair_type'(pr_prod_ff[a][2]) +
                       cbpe_pkg::pair_type'(pr_prod_ff[a][3]);
      end
   end

   // ---------------- stage s2: full sum ----------------
   logic               s2_valid_ff;
   cbpe_pkg::acc_type  s2_acc_ff [cbpe_pkg::NUM_AXES];
   cbpe_pkg::acc_type  s2_acc_in [cbpe_pkg::NUM_AXES];
   cbpe_pkg::meta_type s2_meta_ff;

   always_comb begin
      for (int a = 0; a < cbpe_pkg::NUM_AXES; a++) begin
         s2_acc_in[a] = cbpe_pkg::acc_type'(s1_lo_ff[a]) + cbpe_pkg::acc_type'(s1_hi_ff[a]);
      end
   end

   // ---------------- output register: round and saturate ----------------
   cbpe_pkg::coord_type rsp_pos_ff [cbpe_pkg::NUM_AXES];
   cbpe_pkg::coord_type rsp_pos_in [cbpe_pkg::NUM_AXES];
   cbpe_pkg::meta_type  rsp_meta_ff;

   always_comb begin
      for (int a = 0; a < cbpe_pkg::NUM_AXES; a++) begin
         rsp_pos_in[a] = round_sat(s2_acc_ff[a]);
      end
   end

   // valid bits travel with the data, all gated by the common advance
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff  <= 1'b0;
         f2_valid_ff  <= 1'b0;
         f3_valid_ff  <= 1'b0;
         ts_valid_ff  <= 1'b0;
         w1_valid_ff  <= 1'b0;
         w2_valid_ff  <= 1'b0;
         w3_valid_ff  <= 1'b0;
         pr_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff  <= req_ch.valid;
         f2_valid_ff  <= f1_valid_ff;
         f3_valid_ff  <= f2_valid_ff;
         ts_valid_ff  <= dv_valid;
         w1_valid_ff  <= ts_valid_ff;
         w2_valid_ff  <= w1_valid_ff;
         w3_valid_ff  <= w2_valid_ff;
         pr_valid_ff  <= w3_valid_ff;
         s1_valid_ff  <= pr_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         f1_num_ff   <= f1_num_in;
         f1_den_ff   <= f1_den_in;
         f2_anum_ff  <= f2_anum_in;
         f2_aden_ff  <= f2_aden_in;
         f2_degen_ff <= f2_degen_in;
         f2_neg_ff   <= f2_neg_in;
         f3_num_ff   <= f3_num_in;
         f3_den_ff   <= f2_aden_ff;
         f3_side_ff  <= f3_side_in;
         ts_u_ff     <= ts_u_in;
         ts_meta_ff  <= ts_meta_in;
         w1_uu_ff    <= w1_uu_in;
         w1_tt_ff    <= w1_tt_in;
         w1_u_ff     <= ts_u_ff;
         w1_meta_ff  <= ts_meta_ff;
         w2_raw_ff   <= w2_raw_in;
         w2_meta_ff  <= w1_meta_ff;
         w3_weight_ff <= w3_weight_in;
         w3_meta_ff  <= w2_meta_ff;
         pr_prod_ff  <= pr_prod_in;
         pr_meta_ff  <= w3_meta_ff;
         s1_lo_ff    <= s1_lo_in;
         s1_hi_ff    <= s1_hi_in;
         s1_meta_ff  <= pr_meta_ff;
         s2_acc_ff   <= s2_acc_in;
         s2_meta_ff  <= s1_meta_ff;
         rsp_pos_ff  <= rsp_pos_in;
         rsp_meta_ff <= s2_meta_ff;
      end
   end

   // result word
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pos_x      = rsp_pos_ff[cbpe_pkg::AXIS_X];
   assign rsp_ch.pos_y      = rsp_pos_ff[cbpe_pkg::AXIS_Y];
   assign rsp_ch.pos_z      = rsp_pos_ff[cbpe_pkg::AXIS_Z];
   assign rsp_ch.param_t    = rsp_meta_ff.t;
   assign rsp_ch.clamped    = rsp_meta_ff.clamped;
   assign rsp_ch.degenerate = rsp_meta_ff.degenerate;

   // ---------------- checks ----------------
   // zero span always yields t of zero and no clamp
   a_degen_t_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_meta_ff.degenerate |-> rsp_meta_ff.t == '0 && !rsp_meta_ff.clamped)
      else $error("degenerate word with nonzero t or clamp");

   // t never exceeds one
   a_t_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_meta_ff.t <= cbpe_pkg::T_ONE)
      else $error("t above one");

   // a clamped t sits on one of the bounds
   a_clamp_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_meta_ff.clamped |->
         rsp_meta_ff.t == '0 || rsp_meta_ff.t == cbpe_pkg::T_ONE)
      else $error("clamped t not on a bound");

   // a stalled result stays valid and holds its t and flags
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> rsp_valid_ff && $stable(rsp_meta_ff))
      else $error("result lost during stall");

endmodule

`default_nettype wire

FILE: rtl/core/cbpe_divider.sv
// ----------------------------------------------------------------------------
// cbpe_divider
// pipelined restoring divider, one quotient bit per stage, num <= den
// ----------------------------------------------------------------------------
`default_nettype none

module cbpe_divider (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          advance,
   input  wire                          in_valid,
   input  wire cbpe_pkg::mag_type       in_num,
   input  wire cbpe_pkg::mag_type       in_den,
   input  wire cbpe_pkg::div_side_type  in_side,
   output logic                         out_valid,
   output cbpe_pkg::tparam_type         out_quot,
   output cbpe_pkg::div_side_type       out_side
);

   // stage k resolves quotient bit T_WIDTH-1-k
   logic [cbpe_pkg::DIV_STAGES-1:0]         valid_ff;
   logic [cbpe_pkg::REM_WIDTH-1:0]          rem_ff   [cbpe_pkg::DIV_STAGES-1];
   logic [cbpe_pkg::REM_WIDTH-1:0]          rem_in   [cbpe_pkg::DIV_STAGES-1];
   cbpe_pkg::mag_type                       den_ff   [cbpe_pkg::DIV_STAGES-1];
   cbpe_pkg::tparam_type                    quot_ff  [cbpe_pkg::DIV_STAGES];
   cbpe_pkg::tparam_type                    quot_in  [cbpe_pkg::DIV_STAGES];
   cbpe_pkg::div_side_type                  side_ff  [cbpe_pkg::DIV_STAGES];

   logic [cbpe_pkg::REM_WIDTH-1:0]          src_rem  [cbpe_pkg::DIV_STAGES];
   cbpe_pkg::mag_type                       src_den  [cbpe_pkg::DIV_STAGES];
   cbpe_pkg::tparam_type                    src_quot [cbpe_pkg::DIV_STAGES];
   cbpe_pkg::div_side_type                  src_side [cbpe_pkg::DIV_STAGES];
   logic [cbpe_pkg::DIV_STAGES-1:0]         src_valid;
   logic [cbpe_pkg::DIV_STAGES-1:0]         take;
   logic [cbpe_pkg::REM_WIDTH-1:0]          diff     [cbpe_pkg::DIV_STAGES-1];

   always_comb begin
      src_rem[0]   = {1'b0, in_num};
      src_den[0]   = in_den;
      src_quot[0]  = '0;
      src_side[0]  = in_side;
      src_valid[0] = in_valid;
      for (int k = 1; k < cbpe_pkg::DIV_STAGES; k++) begin
         src_rem[k]   = rem_ff[k-1];
         src_den[k]   = den_ff[k-1];
         src_quot[k]  = quot_ff[k-1];
         src_side[k]  = side_ff[k-1];
         src_valid[k] = valid_ff[k-1];
      end
      for (int k = 0; k < cbpe_pkg::DIV_STAGES; k++) begin
         take[k]    = src_rem[k] >= {1'b0, src_den[k]};
         quot_in[k] = {src_quot[k][cbpe_pkg::T_WIDTH-2:0], take[k]};
      end
      // partial remainder stays below twice the divisor
      for (int k = 0; k < cbpe_pkg::DIV_STAGES - 1; k++) begin
         diff[k]   = src_rem[k] - {1'b0, src_den[k]};
         rem_in[k] = take[k] ? {diff[k][cbpe_pkg::REM_WIDTH-2:0], 1'b0}
                             : {src_rem[k][cbpe_pkg::REM_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < cbpe_pkg::DIV_STAGES; k++) begin
            quot_ff[k] <= quot_in[k];
            side_ff[k] <= src_side[k];
         end
         for (int k = 0; k < cbpe_pkg::DIV_STAGES - 1; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= src_den[k];
         end
      end
   end

   assign out_valid = valid_ff[cbpe_pkg::DIV_STAGES-1];
   assign out_quot  = quot_ff[cbpe_pkg::DIV_STAGES-1];
   assign out_side  = side_ff[cbpe_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire
